@@ hdl/scd_pkg.sv @@
// shared types, constants and the crc-8 byte update for the scratchpad checker
`default_nettype none

package scd_pkg;

    localparam int BYTE_W       = 8;
    localparam int TEMP_W       = 16;
    localparam int RES_W        = 2;
    localparam int IDX_W        = 4;
    localparam int KEPT_COUNT   = 5;
    localparam int CRC_SPAN_DEF = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_LSB   = 8'h01;
    localparam logic [BYTE_W-1:0] RES_MASK  = 8'h60;
    localparam int                RES_SHIFT = 5;
    localparam logic [RES_W-1:0]  RES_MAX   = 2'd3;

    // kept byte positions
    localparam int KB_TEMP_LSB = 0;
    localparam int KB_TEMP_MSB = 1;
    localparam int KB_HIGH     = 2;
    localparam int KB_LOW      = 3;
    localparam int KB_CONFIG   = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] scratch_byte;
        logic              frame_start;
    } t_in_beat;

    typedef struct packed {
        logic                     crc_ok;
        logic [BYTE_W-1:0]        crc_value;
        logic signed [TEMP_W-1:0] temperature_q4;
        logic signed [BYTE_W-1:0] high_alarm;
        logic signed [BYTE_W-1:0] low_alarm;
        logic [BYTE_W-1:0]        config_byte;
        logic [RES_W-1:0]         resolution_code;
    } t_result;

    // reflected crc-8, lsb first, unrolled over the eight bits
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_LSB) != '0) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/scd_if.sv @@
// valid/ready channel interfaces for scratchpad bytes and decoded results
`default_nettype none

interface scd_in_if import scd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] scratch_byte;
    logic              frame_start;

    modport source (output valid, output scratch_byte, output frame_start, input ready);
    modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

interface scd_out_if import scd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     crc_ok;
    logic [BYTE_W-1:0]        crc_value;
    logic signed [TEMP_W-1:0] temperature_q4;
    logic signed [BYTE_W-1:0] high_alarm;
    logic signed [BYTE_W-1:0] low_alarm;
    logic [BYTE_W-1:0]        config_byte;
    logic [RES_W-1:0]         resolution_code;

    modport source (output valid, output crc_ok, output crc_value, output temperature_q4,
                    output high_alarm, output low_alarm, output config_byte,
                    output resolution_code, input ready);
    modport sink   (input valid, input crc_ok, input crc_value, input temperature_q4,
                    input high_alarm, input low_alarm, input config_byte,
                    input resolution_code, output ready);
endinterface

`default_nettype wire

@@ hdl/scd_in_stage.sv @@
// input register for scratchpad byte beats
`default_nettype none

module scd_in_stage import scd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scd_in_if.sink    i_in,
    input  wire logic i_take,
    output t_in_beat  o_beat,
    output logic      o_valid
);

    logic     r_valid;
    t_in_beat r_beat;
    logic     w_accept;

    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beat.scratch_byte <= i_in.scratch_byte;
            r_beat.frame_start  <= i_in.frame_start;
        end
    end

    assign o_beat  = r_beat;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

@@ hdl/scd_core.sv @@
// frame tracking, running crc, kept bytes and result decode
`default_nettype none

module scd_core import scd_pkg::*; #(
    parameter int CRC_SPAN = CRC_SPAN_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_beat i_beat,
    input  wire logic     i_out_free,
    output logic          o_take,
    output logic          o_res_valid,
    output t_result       o_result
);

    logic [IDX_W-1:0]  r_byte_index, n_byte_index, w_idx;
    logic [BYTE_W-1:0] r_crc_acc, n_crc_acc, w_crc_base;
    logic [BYTE_W-1:0] r_kept [KEPT_COUNT];
    logic              w_last;
    logic [BYTE_W-1:0] w_cfg;
    logic [RES_W-1:0]  w_res;
    logic [TEMP_W-1:0] w_raw, w_mask;

    always_comb begin
        w_idx      = i_beat.frame_start ? '0 : r_byte_index;
        w_crc_base = i_beat.frame_start ? '0 : r_crc_acc;
        w_last     = w_idx >= IDX_W'(CRC_SPAN);
        if (w_last) begin
            n_crc_acc    = '0;
            n_byte_index = '0;
        end else begin
            n_crc_acc    = crc8_byte(w_crc_base, i_beat.scratch_byte);
            n_byte_index = w_idx + IDX_W'(1);
        end
    end

    assign o_take      = i_valid && (!w_last || i_out_free);
    assign o_res_valid = i_valid && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_acc    <= '0;
            r_byte_index <= '0;
        end else if (o_take) begin
            r_crc_acc    <= n_crc_acc;
            r_byte_index <= n_byte_index;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KEPT_COUNT; k++) begin
            if (o_take && !w_last && w_idx == IDX_W'(k)) begin
                r_kept[k] <= i_beat.scratch_byte;
            end
        end
    end

    // resolution decode and fraction masking
    always_comb begin
        w_cfg  = r_kept[KB_CONFIG];
        w_res  = RES_W'((w_cfg & RES_MASK) >> RES_SHIFT);
        w_raw  = {r_kept[KB_TEMP_MSB], r_kept[KB_TEMP_LSB]};
        w_mask = {TEMP_W{1'b1}} << (RES_MAX - w_res);

        o_result.crc_ok          = (r_crc_acc == i_beat.scratch_byte);
        o_result.crc_value       = r_crc_acc;
        o_result.temperature_q4  = w_raw & w_mask;
        o_result.high_alarm      = r_kept[KB_HIGH];
        o_result.low_alarm       = r_kept[KB_LOW];
        o_result.config_byte     = w_cfg;
        o_result.resolution_code = w_res;
    end

`ifndef ASSERT_OFF
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= IDX_W'(CRC_SPAN))
        else $error("byte index beyond crc byte position");

    a_wrap_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && o_res_valid |=> r_byte_index == '0 && r_crc_acc == '0)
        else $error("frame state not cleared after result");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_beat.frame_start |=> r_byte_index == IDX_W'(1))
        else $error("frame start did not restart the frame");

    a_no_result_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_beat.frame_start |-> !o_res_valid)
        else $error("result raised on a frame start beat");
`endif

endmodule

`default_nettype wire

@@ hdl/scd_out_stage.sv @@
// result register driving the output channel
`default_nettype none

module scd_out_stage import scd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    scd_out_if.source    o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.crc_ok          = r_result.crc_ok;
    assign o_out.crc_value       = r_result.crc_value;
    assign o_out.temperature_q4  = r_result.temperature_q4;
    assign o_out.high_alarm      = r_result.high_alarm;
    assign o_out.low_alarm       = r_result.low_alarm;
    assign o_out.config_byte     = r_result.config_byte;
    assign o_out.resolution_code = r_result.resolution_code;

endmodule

`default_nettype wire

@@ hdl/scratchpad_crc_check_and_decode.sv @@
// top level: scratchpad crc check and temperature decode
//
//   channel  dir  beat                              when
//   i_in     in   scratch_byte, frame_start         every scratchpad byte
//   o_out    out  crc, temperature, alarms, config  once per crc byte
//
// one byte per cycle while the output is not stalled; a result is offered once
// its crc byte has passed the input register and then the result register
// the crc-8 update is an unrolled xor network feeding the running crc register
// reset clears frame position, running crc and both valid flags
// kept bytes are not reset; a stalled output holds only a crc byte in the input
// register, and the input with it; other bytes never wait on the output
`default_nettype none

module scratchpad_crc_check_and_decode import scd_pkg::*; #(
    parameter int CRC_SPAN = CRC_SPAN_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scd_in_if.sink    i_in,
    scd_out_if.source o_out
);

    t_in_beat w_beat;
    t_result  w_result;
    logic     w_beat_valid;
    logic     w_take;
    logic     w_res_valid;
    logic     w_out_free;

    scd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_beat  (w_beat),
        .o_valid (w_beat_valid)
    );

    scd_core #(
        .CRC_SPAN (CRC_SPAN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_beat_valid),
        .i_beat      (w_beat),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    scd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_res_valid),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
